// ===== rtl/core/fdsa_pkg.sv =====
package fdsa_pkg;

   // Fixed field widths
   localparam int INDEX_W = 10;
   localparam int FENCE_W = 64;
   localparam int ADDR_W  = 48;
   localparam int STRIDE_W = 9;
   localparam int LIMIT_W = 11;
   localparam int STATUS_W = 2;
   localparam int CSR_INDEX_W = 2;

   // Operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAP_BASE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIDE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_LIMIT = 2'd2;

   // Register reset values
   localparam logic [ADDR_W-1:0]   HEAP_BASE_RST  = '0;
   localparam logic [STRIDE_W-1:0] STRIDE_RST     = 9'd32;
   localparam logic [LIMIT_W-1:0]  SLOT_LIMIT_RST = 11'd1024;

   typedef struct packed {
      logic                operation;
      logic [INDEX_W-1:0]  slot_index;
      logic [FENCE_W-1:0]  current_fence;
      logic [FENCE_W-1:0]  completed_fence;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  granted_index;
      logic [ADDR_W-1:0]   slot_address;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Deferred free queue entry
   typedef struct packed {
      logic [INDEX_W-1:0] idx;
      logic [FENCE_W-1:0] fence;
   } qentry_type;

   typedef struct packed {
      logic push;
      logic read;
      logic pop;
   } q_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

   typedef struct packed {
      logic read;
      logic pop;
      logic push;
   } s_ctl_type;

endpackage

// ===== rtl/core/fdsa_queue.sv =====
module fdsa_queue import fdsa_pkg::*; #(
   parameter int SLOTS = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  q_ctl_type  ctl,
   input  qentry_type push_data,
   output qentry_type rd_data,
   output q_stat_type stat
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   qentry_type mem [SLOTS];
   qentry_type rd_ff;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;

   // Advance pointers and fill level
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.push) begin
         tail_in = (tail_ff == IW'(SLOTS - 1)) ? '0 : tail_ff + IW'(1);
      end
      if (ctl.pop) begin
         head_in = (head_ff == IW'(SLOTS - 1)) ? '0 : head_ff + IW'(1);
      end
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.pop && !ctl.push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Entry storage: write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= push_data;
      end
      if (ctl.read) begin
         rd_ff <= mem[head_ff];
      end
   end

   assign rd_data    = rd_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(SLOTS));

endmodule

// ===== rtl/core/fdsa_stack.sv =====
module fdsa_stack import fdsa_pkg::*; #(
   parameter int SLOTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  s_ctl_type                     ctl,
   input  logic [INDEX_W-1:0]            push_data,
   output logic [((($clog2(SLOTS)) > INDEX_W) ? $clog2(SLOTS) : INDEX_W)-1:0] rd_data,
   output logic [$clog2(SLOTS + 1)-1:0]  count
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int EW = (IW > INDEX_W) ? IW : INDEX_W;

   logic [EW-1:0] mem [SLOTS];
   logic [EW-1:0] mem_rd_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] reach_ff, reach_in;
   logic [CW-1:0] pos_ff;
   logic          written_ff;
   logic [CW-1:0] count_dec;
   logic [CW-1:0] count_inc;

   assign count_dec = count_ff - CW'(1);
   assign count_inc = count_ff + CW'(1);

   // Track the stack pointer and the highest depth ever reached
   always_comb begin
      count_in = count_ff;
      reach_in = reach_ff;
      if (ctl.push && count_ff != '0) begin
         count_in = count_dec;
      end else if (ctl.pop) begin
         count_in = count_inc;
         if (count_inc > reach_ff) begin
            reach_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         reach_ff <= '0;
      end else begin
         count_ff <= count_in;
         reach_ff <= reach_in;
      end
   end

   // Push below the pointer, read at the pointer; entries at or above the reach
   // mark were never written and hold their own position
   always_ff @(posedge clock) begin
      if (ctl.push && count_ff != '0) begin
         mem[count_dec[IW-1:0]] <= EW'(push_data);
      end
      if (ctl.read) begin
         mem_rd_ff  <= mem[count_ff[IW-1:0]];
         pos_ff     <= count_ff;
         written_ff <= (count_ff < reach_ff);
      end
   end

   assign rd_data = written_ff ? mem_rd_ff : EW'(pos_ff);
   assign count   = count_ff;

endmodule

// ===== rtl/core/fenced_deferred_slot_allocator_top.sv =====
// Free: result strobe in the cycle after accept; busy stays low, one item per cycle.
// Allocate: busy through a queue read and check per reclaimed queue entry, a last queue
// read, one more check when a pending entry is found not yet complete, then stack read,
// multiply and add; result in the next cycle. Out of slots stops at stack read.
// Results are never stalled. Fence compare and index multiply are shared units.
// Synchronous active-high reset: registers to defaults, all slots free, queue empty.
module fenced_deferred_slot_allocator_top import fdsa_pkg::*; #(
   parameter int SLOTS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]      csr_wdata
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int EW = (IW > INDEX_W) ? IW : INDEX_W;
   localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
   localparam int PW = EW + STRIDE_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_QREAD  = 3'd1;
   localparam logic [2:0] S_QCHECK = 3'd2;
   localparam logic [2:0] S_SREAD  = 3'd3;
   localparam logic [2:0] S_MUL    = 3'd4;
   localparam logic [2:0] S_ADD    = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   heap_base_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [LIMIT_W-1:0]  slot_limit_ff;
   logic [FENCE_W-1:0]  done_ff, done_in;
   logic [PW-1:0]       product_ff, product_in;
   logic [EW-1:0]       slot_ff, slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   q_ctl_type           q_ctl;
   q_stat_type          q_stat;
   qentry_type          q_push;
   qentry_type          q_rd;
   s_ctl_type           s_ctl;
   logic [EW-1:0]       s_rd;
   logic [CW-1:0]       s_count;
   logic [LW-1:0]       limit_eff;
   logic                accept;
   logic                fence_done;

   fdsa_queue #(.SLOTS(SLOTS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (q_ctl),
      .push_data (q_push),
      .rd_data   (q_rd),
      .stat      (q_stat)
   );

   fdsa_stack #(.SLOTS(SLOTS)) u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctl       (s_ctl),
      .push_data (q_rd.idx),
      .rd_data   (s_rd),
      .count     (s_count)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= HEAP_BASE_RST;
         stride_ff     <= STRIDE_RST;
         slot_limit_ff <= SLOT_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEAP_BASE:  heap_base_ff  <= csr_wdata;
            CSR_STRIDE:     stride_ff     <= csr_wdata[STRIDE_W-1:0];
            CSR_SLOT_LIMIT: slot_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the limit to the stack depth
   assign limit_eff = (LW'(slot_limit_ff) > LW'(SLOTS)) ? LW'(SLOTS) : LW'(slot_limit_ff);

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign fence_done = (q_rd.fence <= done_ff);

   assign q_push.idx   = req_data.slot_index;
   assign q_push.fence = req_data.current_fence;

   // Sequencer: queue a free if room, or drain completed entries then pop a slot if any
   always_comb begin
      state_in     = state_ff;
      done_in      = done_ff;
      product_in   = product_ff;
      slot_in      = slot_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      q_ctl        = '0;
      s_ctl        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               done_in = req_data.completed_fence;
               if (req_data.operation == OP_FREE) begin
                  q_ctl.push                = !q_stat.full;
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.granted_index = '0;
                  rsp_data_in.slot_address  = '0;
                  rsp_data_in.status        = q_stat.full ? ST_QUEUE_FULL : ST_OK;
               end else begin
                  state_in = S_QREAD;
               end
            end
         end
         S_QREAD: begin
            if (q_stat.empty) begin
               state_in = S_SREAD;
            end else begin
               q_ctl.read = 1'b1;
               state_in   = S_QCHECK;
            end
         end
         S_QCHECK: begin
            if (fence_done) begin
               q_ctl.pop  = 1'b1;
               s_ctl.push = 1'b1;
               state_in   = S_QREAD;
            end else begin
               state_in = S_SREAD;
            end
         end
         S_SREAD: begin
            if (LW'(s_count) >= limit_eff) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.granted_index = '0;
               rsp_data_in.slot_address  = '0;
               rsp_data_in.status        = ST_NO_SLOT;
               state_in                  = S_IDLE;
            end else begin
               s_ctl.read = 1'b1;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            slot_in    = s_rd;
            product_in = PW'(s_rd) * PW'(stride_ff);
            s_ctl.pop  = 1'b1;
            state_in   = S_ADD;
         end
         S_ADD: begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.granted_index = slot_ff[INDEX_W-1:0];
            rsp_data_in.slot_address  = heap_base_ff + ADDR_W'(product_ff);
            rsp_data_in.status        = ST_OK;
            state_in                  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      done_ff     <= done_in;
      product_ff  <= product_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A free answers in the next cycle
   a_free_answers: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.operation == OP_FREE |=> rsp_valid)
      else $error("free item got no result");

   // Each allocate ends with its result
   a_fell_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("allocate finished without result");

   // Results come only from a free accept or an allocate end
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(reset) |->
         $past(accept && req_data.operation == OP_FREE) ||
         $past(state_ff == S_ADD) || $past(state_ff == S_SREAD))
      else $error("unexpected result strobe");

   // Stack pointer never passes the depth
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      s_count <= CW'(SLOTS))
      else $error("allocated count beyond depth");

endmodule

// ===== tb/sv/alloc_tb_pkg.sv =====
package alloc_tb_pkg;
   import fdsa_pkg::*;

   localparam int SLOTS = 1024;

   // Shadow of the allocator: free stack, deferred free queue and registers
   class alloc_shadow;
      logic [ADDR_W-1:0]   heap_base;
      logic [STRIDE_W-1:0] stride;
      logic [LIMIT_W-1:0]  slot_limit;

      logic [INDEX_W-1:0]  free_slots[SLOTS];
      int unsigned         in_use;
      logic [INDEX_W-1:0]  deferred_index[SLOTS];
      logic [FENCE_W-1:0]  deferred_fence[SLOTS];
      int unsigned         q_head;
      int unsigned         q_tail;
      int unsigned         q_depth;

      rsp_type             owed_results[$];
      logic [INDEX_W-1:0]  held_slots[$];
      int unsigned         errors;
      int unsigned         n_grant;
      int unsigned         n_no_slot;
      int unsigned         n_full;
      int unsigned         n_reclaimed;
      int unsigned         n_discarded;

      function void reset_state();
         heap_base  = HEAP_BASE_RST;
         stride     = STRIDE_RST;
         slot_limit = SLOT_LIMIT_RST;
         for (int i = 0; i < SLOTS; i++) begin
            free_slots[i] = INDEX_W'(i);
         end
         in_use      = 0;
         q_head      = 0;
         q_tail      = 0;
         q_depth     = 0;
         errors      = 0;
         n_grant     = 0;
         n_no_slot   = 0;
         n_full      = 0;
         n_reclaimed = 0;
         n_discarded = 0;
         owed_results.delete();
         held_slots.delete();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [ADDR_W-1:0] value);
         case (idx)
            CSR_HEAP_BASE:  heap_base  = value;
            CSR_STRIDE:     stride     = value[STRIDE_W-1:0];
            CSR_SLOT_LIMIT: slot_limit = value[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      // Work out the result of one accepted item and queue it
      function void note_request(req_type req);
         rsp_type            r;
         int unsigned        lim;
         logic [INDEX_W-1:0] slot;
         r = '0;
         if (req.operation == OP_FREE) begin
            if (q_depth >= SLOTS) begin
               r.status = ST_QUEUE_FULL;
               n_full++;
            end else begin
               deferred_index[q_tail] = req.slot_index;
               deferred_fence[q_tail] = req.current_fence;
               q_tail = (q_tail + 1) % SLOTS;
               q_depth++;
            end
         end else begin
            // reclaim completed entries in order; drop them when nothing is out
            while (q_depth > 0 && deferred_fence[q_head] <= req.completed_fence) begin
               if (in_use > 0) begin
                  in_use--;
                  free_slots[in_use] = deferred_index[q_head];
                  n_reclaimed++;
               end else begin
                  n_discarded++;
               end
               q_head = (q_head + 1) % SLOTS;
               q_depth--;
            end
            lim = (slot_limit > SLOTS) ? SLOTS : slot_limit;
            if (in_use >= lim) begin
               r.status = ST_NO_SLOT;
               n_no_slot++;
            end else begin
               slot = free_slots[in_use];
               in_use++;
               r.granted_index = slot;
               r.slot_address  = heap_base + ({38'b0, slot} * {39'b0, stride});
               r.status        = ST_OK;
               held_slots.insert(held_slots.size(), slot);
               n_grant++;
            end
         end
         owed_results.insert(owed_results.size(), r);
      endfunction

      // Compare one result with the oldest owed one
      function void check_result(rsp_type got);
         rsp_type want;
         if (owed_results.size() == 0) begin
            $error("result with nothing owed: index %0d address %h status %0d",
                   got.granted_index, got.slot_address, got.status);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         if (got.granted_index !== want.granted_index) begin
            $error("granted_index: expected %0d, got %0d", want.granted_index,
                   got.granted_index);
            errors++;
         end
         if (got.slot_address !== want.slot_address) begin
            $error("slot_address: expected %h, got %h", want.slot_address,
                   got.slot_address);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

endpackage

// ===== tb/sv/testbench.sv =====
module testbench;
   import fdsa_pkg::*;
   import alloc_tb_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_type                req_data = '0;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0]      csr_wdata = '0;

   alloc_shadow            shadow;
   int unsigned            taken = 0;
   logic [FENCE_W-1:0]     fence_clock;

   fenced_deferred_slot_allocator_top #(.SLOTS(SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Note accepted items and check results at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            shadow.note_request(req_data);
            taken++;
         end
         if (rsp_valid) begin
            shadow.check_result(rsp_data);
         end
      end
   end

   initial begin
      #2000000;
      $display("[fenced_deferred_slot_allocator_top] ERROR");
      $finish;
   end

   // Write all three registers while idle, one per cycle
   task automatic set_config(logic [ADDR_W-1:0] base, logic [STRIDE_W-1:0] stride,
                             logic [LIMIT_W-1:0] limit);
      csr_we    <= 1'b1;
      csr_index <= CSR_HEAP_BASE;
      csr_wdata <= base;
      shadow.write_reg(CSR_HEAP_BASE, base);
      @(negedge clock);
      csr_index <= CSR_STRIDE;
      csr_wdata <= {39'b0, stride};
      shadow.write_reg(CSR_STRIDE, {39'b0, stride});
      @(negedge clock);
      csr_index <= CSR_SLOT_LIMIT;
      csr_wdata <= {37'b0, limit};
      shadow.write_reg(CSR_SLOT_LIMIT, {37'b0, limit});
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Present one item, hold it until taken, then maybe idle
   task automatic send(req_type r, int pct);
      int unsigned seen;
      seen = taken;
      start    <= 1'b1;
      req_data <= r;
      do @(negedge clock); while (taken == seen);
      if ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   // Drop start and wait for every owed result
   task automatic settle();
      start <= 1'b0;
      while (shadow.owed_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic req_type alloc_req(logic [FENCE_W-1:0] done);
      req_type r;
      r.operation       = OP_ALLOC;
      r.slot_index      = INDEX_W'($urandom);
      r.current_fence   = {$urandom, $urandom};
      r.completed_fence = done;
      return r;
   endfunction

   function automatic req_type free_req(logic [INDEX_W-1:0] idx, logic [FENCE_W-1:0] cur);
      req_type r;
      r.operation       = OP_FREE;
      r.slot_index      = idx;
      r.current_fence   = cur;
      r.completed_fence = {$urandom, $urandom};
      return r;
   endfunction

   // Mostly well-formed traffic on a rising fence clock, some noise
   task automatic random_item(int pct);
      req_type r;
      int      pick;
      int      k;
      pick = $urandom_range(0, 99);
      r.operation       = OP_ALLOC;
      r.slot_index      = INDEX_W'($urandom);
      r.current_fence   = {$urandom, $urandom};
      r.completed_fence = {$urandom, $urandom};
      if (pick < 45) begin
         if (pick < 41) r.completed_fence = fence_clock - $urandom_range(0, 6);
      end else if (pick < 90) begin
         r.operation     = OP_FREE;
         r.current_fence = fence_clock + $urandom_range(0, 3);
         if (shadow.held_slots.size() > 0 && pick < 86) begin
            k = $urandom_range(0, shadow.held_slots.size() - 1);
            r.slot_index = shadow.held_slots[k];
            shadow.held_slots.delete(k);
         end
      end else begin
         r.operation = logic'($urandom_range(0, 1));
      end
      fence_clock = fence_clock + $urandom_range(0, 2);
      send(r, pct);
   endtask

   task automatic run_phase(int count, int pct);
      for (int i = 0; i < count; i++) begin
         random_item(pct);
      end
      settle();
   endtask

   initial begin
      shadow = new;
      shadow.reset_state();
      fence_clock = {$urandom, $urandom};
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Top base with a stride of 256: address wraps past 2^48
      set_config({ADDR_W{1'b1}}, 9'd256, 11'd1024);
      // reclaim with nothing allocated drops the entry
      send(free_req(10'd5, '0), 0);
      send(alloc_req('0), 0);
      send(alloc_req('0), 0);
      send(free_req(10'h3FF, '0), 0);
      send(free_req(10'h000, {FENCE_W{1'b1}}), 0);
      // first entry complete, second still pending
      send(alloc_req('0), 0);
      send(alloc_req({FENCE_W{1'b1}}), 0);
      send(alloc_req({FENCE_W{1'b1}}), 0);
      settle();

      // Zero stride and a limit above the slot count
      set_config(48'h5A5A_0000_1234, 9'd0, 11'd2047);
      send(alloc_req('0), 0);
      send(alloc_req('0), 0);
      send(free_req(10'h2AA, {FENCE_W{1'b1}}), 0);
      send(alloc_req(64'd1), 0);
      settle();

      // Zero limit: every allocate is out of slots
      set_config('0, 9'd511, 11'd0);
      send(alloc_req({FENCE_W{1'b1}}), 0);
      send(free_req(10'h155, 64'h5555_5555_5555_5555), 0);
      send(alloc_req('0), 0);
      settle();

      // Limit below the count already out
      set_config(48'h0000_FFFF_0000, 9'd1, 11'd1);
      send(alloc_req('0), 0);
      send(free_req(10'd0, '0), 0);
      settle();

      // Random traffic, sender idling
      set_config(ADDR_W'({$urandom, $urandom}), STRIDE_W'($urandom_range(1, 256)),
                 LIMIT_W'($urandom_range(4, 40)));
      run_phase(190, 35);

      set_config(ADDR_W'({$urandom, $urandom}), 9'd1, 11'd1024);
      run_phase(190, 58);

      // Fill the deferred queue past capacity, then drain it in one allocate
      set_config('0, 9'd256, 11'd1024);
      for (int i = 0; i < SLOTS + 4; i++) begin
         send(free_req(INDEX_W'($urandom), {FENCE_W{1'b1}}), 0);
      end
      send(alloc_req({FENCE_W{1'b1}}), 0);
      send(alloc_req({FENCE_W{1'b1}}), 0);
      settle();

      // Random traffic, no idling
      set_config(ADDR_W'({$urandom, $urandom}), STRIDE_W'($urandom_range(1, 256)),
                 LIMIT_W'($urandom_range(1, 1024)));
      run_phase(180, 0);

      $display("covered %0d items: %0d grants, %0d out of slots, %0d queue full",
               taken, shadow.n_grant, shadow.n_no_slot, shadow.n_full);
      $display("deferred slots reclaimed %0d, dropped with nothing out %0d",
               shadow.n_reclaimed, shadow.n_discarded);
      if (shadow.errors == 0) begin
         $display("[fenced_deferred_slot_allocator_top] OK");
      end else begin
         $display("[fenced_deferred_slot_allocator_top] ERROR");
      end
      $finish;
   end

endmodule
